// ----- sv/ppu_pkg.sv -----
// shared types and constants for the particle pool
`default_nettype none
package ppu_pkg;
    localparam int POOL_DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int STEP_MAX = 102;
    localparam int AGE_MAX = 16383;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SPAWN = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_DRAW  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_ENTRY   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] time_step;
        logic signed [15:0] spawn_x;
        logic signed [15:0] spawn_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [13:0]        lifetime;
        logic [7:0]         size;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         live_count;
        logic signed [15:0] draw_x;
        logic signed [15:0] draw_y;
        logic [7:0]         draw_radius;
        logic [7:0]         draw_red;
        logic [7:0]         draw_green;
        logic [7:0]         draw_blue;
        logic               last;
    } res_t;

    // one stored particle
    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [13:0]        age;
        logic [13:0]        life;
        logic [31:0]        look;
    } ent_t;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture request
        logic       rd;        // read entry at rd_idx
        logic [5:0] rd_idx;
        logic       wr_spawn;  // write new particle at wr_idx
        logic       wr_upd;    // write updated entry at wr_idx
        logic       wr_copy;   // write read entry at wr_idx
        logic [5:0] wr_idx;
        logic       div_start;
        logic       emit;      // push result
        logic [1:0] emit_status;
        logic       emit_last;
        logic [6:0] emit_count;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic expired;   // updated age reached life
        logic div_busy;
        logic out_busy;  // output register full and stalled
    } sts_t;
endpackage
`default_nettype wire

// ----- sv/particle_pool_update.sv -----
// Particle pool with clear, spawn, tick and draw requests. Tick walks the
// live particles through the single memory port, writing each survivor
// back and pulling the last entry into the slot of each expiry. Draw runs
// four 25-step divisions per particle (radius and three colours) in one
// shared serial divider. One request is worked at a time; the result
// register lets the next request enter while the final result waits.
`default_nettype none
module particle_pool_update (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire ppu_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output ppu_pkg::res_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_data
);
    import ppu_pkg::*;
    ctl_t ctl;
    sts_t sts;

    ppu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_stall (in_stall),
        .req       (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .ctl       (ctl)
    );

    ppu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (out_data)
    );

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.live_count <= 7'(POOL_DEPTH))
        else $error("live count beyond pool depth");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.last)
        else $error("empty draw not final");
    a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result overwritten while stalled");
endmodule
`default_nettype wire

// ----- sv/ppu_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module ppu_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [24:0] num,
    input  wire logic [16:0] den,
    output logic             busy,
    output logic [24:0]      quo
);
    import ppu_pkg::*;
    logic [24:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [16:0] d_reg, d_next;
    logic [4:0]  n_reg, n_next;
    logic        b_reg, b_next;
    logic [17:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        b_next = b_reg;
        trial  = {r_reg, q_reg[24]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            n_next = 5'd25;
            b_next = 1'b1;
        end
        else if (b_reg)
        begin
            if (!trial[17])
            begin
                r_next = trial[16:0];
                q_next = {q_reg[23:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[15:0], q_reg[24]};
                q_next = {q_reg[23:0], 1'b0};
            end
            n_next = n_reg - 5'd1;
            if (n_reg == 5'd1)
                b_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = b_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

// ----- sv/ppu_datapath.sv -----
// particle memory, motion update, fade division and output register
`default_nettype none
module ppu_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ppu_pkg::req_t req,
    input  wire ppu_pkg::ctl_t ctl,
    output ppu_pkg::sts_t      sts,
    output logic               res_valid,
    input  wire logic          res_stall,
    output ppu_pkg::res_t      res
);
    import ppu_pkg::*;

    ent_t mem [POOL_DEPTH];
    req_t req_reg;
    ent_t rd_reg;
    ent_t upd;
    logic [6:0] step;
    logic [14:0] age_sum;
    logic [13:0] age_new;
    logic [13:0] rem;
    logic signed [15:0] nx, ny;
    logic expired;

    // quotients held between divider runs
    logic [1:0]  phase_reg;
    logic [1:0]  ph;
    logic [7:0]  q_rad_reg, q_r_reg, q_g_reg;
    logic        div_busy;
    logic [24:0] div_quo;
    logic [24:0] div_num;
    logic [16:0] div_den;
    logic        div_go;
    logic        run_reg;
    logic        busy_q;
    logic [9:0]  sz3;
    logic [25:0] rad0_prod;

    res_t out_reg;
    res_t out_next;
    logic vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            req_reg <= req;
    end

    always_comb
    begin
        if (req_reg.time_step[15])
            step = '0;
        else if (req_reg.time_step > 16'sd102)
            step = 7'(STEP_MAX);
        else
            step = req_reg.time_step[6:0];
    end

    function automatic logic signed [15:0] move_sat(
        input logic signed [15:0] p, input logic signed [15:0] v,
        input logic [6:0] s);
        logic signed [23:0] t;
        logic signed [17:0] q;
        begin
            t = 24'(v) * 24'($signed({1'b0, s})) + 24'sd512;
            q = 18'(p) + 18'(t >>> 10);
            if (q > 18'sd32767)
                move_sat = 16'sh7fff;
            else if (q < -18'sd32768)
                move_sat = 16'sh8000;
            else
                move_sat = q[15:0];
        end
    endfunction

    always_comb
    begin
        age_sum = {1'b0, rd_reg.age} + 15'(step);
        age_new = age_sum[14] ? 14'(AGE_MAX) : age_sum[13:0];
        nx = move_sat(rd_reg.px, rd_reg.vx, step);
        ny = move_sat(rd_reg.py, rd_reg.vy, step);
        upd = rd_reg;
        upd.age = age_new;
        upd.px = nx;
        upd.py = ny;
        expired = (age_new >= rd_reg.life);
        rem = (rd_reg.age < rd_reg.life) ? rd_reg.life - rd_reg.age : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
            rd_reg <= mem[ctl.rd_idx];
        if (ctl.wr_spawn)
            mem[ctl.wr_idx] <= '{px: req_reg.spawn_x, py: req_reg.spawn_y,
                vx: req_reg.vel_x, vy: req_reg.vel_y, age: '0,
                life: req_reg.lifetime,
                look: {req_reg.size, req_reg.red, req_reg.green, req_reg.blue}};
        else if (ctl.wr_upd)
            mem[ctl.wr_idx] <= upd;
        else if (ctl.wr_copy)
            mem[ctl.wr_idx] <= rd_reg;
    end

    // radius for a zero life is size*3/5, by reciprocal multiply
    assign sz3 = 10'(rd_reg.look[31:24]) * 10'd3;
    assign rad0_prod = 26'(sz3) * 26'd52429;

    // four divisions per entry: radius, red, green, blue
    // a run started now is captured when phase_reg has moved on to it
    always_comb
    begin
        ph = ctl.div_start ? 2'd0 : phase_reg + 2'd1;
        case (ph)
            2'd0:
            begin
                div_num = 25'(rd_reg.look[31:24]) * 25'({rd_reg.life, 1'b0}
                          + {1'b0, rd_reg.life} + 17'({rem, 1'b0}));
                div_den = 17'(rd_reg.life) * 17'd5;
            end
            2'd1:
            begin
                div_num = 25'(rd_reg.look[23:16]) * 25'(rem);
                div_den = 17'(rd_reg.life);
            end
            2'd2:
            begin
                div_num = 25'(rd_reg.look[15:8]) * 25'(rem);
                div_den = 17'(rd_reg.life);
            end
            default:
            begin
                div_num = 25'(rd_reg.look[7:0]) * 25'(rem);
                div_den = 17'(rd_reg.life);
            end
        endcase
        if (rd_reg.life == '0)
        begin
            div_num = '0;
            div_den = 17'd1;
        end
        div_go = ctl.div_start || (run_reg && !div_busy && !busy_q
                 && phase_reg != 2'd3 && !ctl.div_start);
    end

    ppu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            run_reg   <= 1'b0;
            busy_q    <= 1'b0;
        end
        else
        begin
            busy_q <= div_go;
            if (ctl.div_start)
            begin
                phase_reg <= '0;
                run_reg   <= 1'b1;
            end
            else if (run_reg && !div_busy && !busy_q)
            begin
                if (phase_reg == 2'd3)
                    run_reg <= 1'b0;
                else
                    phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg && !div_busy && !busy_q)
        begin
            case (phase_reg)
                2'd0: q_rad_reg <= (rd_reg.life == '0) ? rad0_prod[25:18] : div_quo[7:0];
                2'd1: q_r_reg <= div_quo[7:0];
                2'd2: q_g_reg <= div_quo[7:0];
                default: q_g_reg <= q_g_reg;
            endcase
        end
    end

    assign sts = '{expired: expired, div_busy: ctl.div_start || run_reg,
                   out_busy: vld_reg && res_stall};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctl.emit)
            vld_reg <= 1'b1;
        else if (!res_stall)
            vld_reg <= 1'b0;
    end

    always_comb
    begin
        out_next = '0;
        out_next.status = ctl.emit_status;
        out_next.live_count = ctl.emit_count;
        out_next.last = ctl.emit_last;
        if (ctl.emit_status == ST_ENTRY)
        begin
            out_next.draw_x = rd_reg.px;
            out_next.draw_y = rd_reg.py;
            out_next.draw_radius = q_rad_reg;
            out_next.draw_red = q_r_reg;
            out_next.draw_green = q_g_reg;
            out_next.draw_blue = div_quo[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
            out_reg <= out_next;
    end

    assign res_valid = vld_reg;
    assign res = out_reg;
endmodule
`default_nettype wire

// ----- sv/ppu_ctrl.sv -----
// command sequencer for the particle pool
`default_nettype none
module ppu_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ppu_pkg::req_t req,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_data,
    input  wire ppu_pkg::sts_t sts,
    output ppu_pkg::ctl_t      ctl
);
    import ppu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_TRD   = 3'd2;
    localparam logic [2:0] S_TCHK  = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DDIV  = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] st_reg, st_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] max_reg;
    logic [6:0] idx_reg, idx_next;
    logic [1:0] cmd_reg;
    logic [1:0] est_reg, est_next;
    logic       elast_reg, elast_next;
    logic [6:0] lim;
    logic       take;

    assign lim = (max_reg > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : max_reg;
    assign req_stall = (st_reg != S_IDLE);
    assign take = req_valid && !req_stall;

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        est_next = est_reg;
        elast_next = elast_reg;
        ctl = '0;
        ctl.load = take;
        ctl.rd_idx = idx_reg[5:0];
        ctl.wr_idx = idx_reg[5:0];
        ctl.emit_status = est_reg;
        ctl.emit_last = elast_reg;
        ctl.emit_count = cnt_reg;
        case (st_reg)
            S_IDLE:
                if (take)
                    st_next = S_DISP;
            S_DISP:
            begin
                idx_next = '0;
                est_next = ST_DONE;
                elast_next = 1'b1;
                st_next = S_EMIT;
                case (cmd_reg)
                    CMD_CLEAR: cnt_next = '0;
                    CMD_SPAWN:
                        if (cnt_reg >= lim)
                            est_next = ST_DROPPED;
                        else
                        begin
                            ctl.wr_spawn = 1'b1;
                            ctl.wr_idx = cnt_reg[5:0];
                            cnt_next = cnt_reg + 7'd1;
                        end
                    CMD_TICK:
                        if (cnt_reg != '0)
                            st_next = S_TRD;
                    default:
                        if (cnt_reg == '0)
                            est_next = ST_EMPTY;
                        else
                            st_next = S_DRD;
                endcase
            end
            S_TRD:
            begin
                ctl.rd = 1'b1;
                st_next = S_TCHK;
            end
            S_TCHK:
                if (sts.expired)
                begin
                    // pull the last entry into this slot, then look again
                    if (idx_reg == cnt_reg - 7'd1)
                    begin
                        cnt_next = cnt_reg - 7'd1;
                        st_next = S_EMIT;
                    end
                    else
                    begin
                        ctl.rd = 1'b1;
                        ctl.rd_idx = 6'(cnt_reg - 7'd1);
                        cnt_next = cnt_reg - 7'd1;
                        // copy happens from rd_reg next cycle
                        st_next = S_DWAIT;
                    end
                end
                else
                begin
                    ctl.wr_upd = 1'b1;
                    if (idx_reg + 7'd1 >= cnt_reg)
                        st_next = S_EMIT;
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                        st_next = S_TRD;
                    end
                end
            S_DWAIT:
                // tick copy or draw division wait
                if (cmd_reg == CMD_TICK)
                begin
                    ctl.wr_copy = 1'b1;
                    st_next = S_TRD;
                end
                else if (!sts.div_busy && !sts.out_busy)
                begin
                    ctl.emit = 1'b1;
                    ctl.emit_status = ST_ENTRY;
                    ctl.emit_last = (idx_reg + 7'd1 == cnt_reg);
                    if (idx_reg + 7'd1 == cnt_reg)
                        st_next = S_IDLE;
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                        st_next = S_DRD;
                    end
                end
            S_DRD:
            begin
                ctl.rd = 1'b1;
                st_next = S_DDIV;
            end
            S_DDIV:
            begin
                ctl.div_start = 1'b1;
                st_next = S_DWAIT;
            end
            default:
                if (!sts.out_busy)
                begin
                    ctl.emit = 1'b1;
                    st_next = S_IDLE;
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            cnt_reg <= '0;
            max_reg <= 7'd64;
            idx_reg <= '0;
            cmd_reg <= CMD_CLEAR;
            est_reg <= ST_DONE;
            elast_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= idx_next;
            est_reg <= est_next;
            elast_reg <= elast_next;
            if (take)
                cmd_reg <= req.command;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
                if (cnt_reg > ((cfg_data > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : cfg_data))
                    cnt_reg <= (cfg_data > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : cfg_data;
            end
            else
                cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire
